// ----- hw/rtl/llwd_pkg.sv -----
// ----------------------------------------------------------------------------
// llwd_pkg
// Shared widths, codes, state type and window entry layout for the dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package llwd_pkg;

  localparam int MAX_WINDOWS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int LOAD_W   = 24;
  localparam int CNT_W    = 4;
  localparam int TICKET_W = 10;
  localparam int STIME_W  = 16;
  localparam int CFG_W    = 3;
  localparam int KIND_W   = 2;
  localparam int WIN_W    = 2;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DRAIN   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEADER   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAINED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_D_RDW,
    ST_D_HDR,
    ST_D_TKT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [LOAD_W-1:0] load;
  } win_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/llwd_wmem.sv -----
// ----------------------------------------------------------------------------
// llwd_wmem
// Window state memory: load and queue count per window, registered read,
// per-entry valid bits so that a cleared entry reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module llwd_wmem #(
  parameter int MAX_WINDOWS = llwd_pkg::MAX_WINDOWS_DEF,
  parameter int WW          = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clr,
  input  wire logic                we,
  input  wire logic [WW-1:0]       waddr,
  input  wire llwd_pkg::win_entry_t wdata,
  input  wire logic                re,
  input  wire logic [WW-1:0]       raddr,
  output llwd_pkg::win_entry_t     rdata
);
  import llwd_pkg::*;

  win_entry_t             mem [MAX_WINDOWS];
  logic [MAX_WINDOWS-1:0] valid_r;
  win_entry_t             rdata_r;
  logic                   rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r  <= mem[raddr];
      rvalid_r <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/llwd_tmem.sv -----
// ----------------------------------------------------------------------------
// llwd_tmem
// Ticket store: one row of queue entries per window, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module llwd_tmem #(
  parameter int MAX_WINDOWS = llwd_pkg::MAX_WINDOWS_DEF,
  parameter int QUEUE_DEPTH = llwd_pkg::QUEUE_DEPTH_DEF,
  parameter int TDEPTH      = MAX_WINDOWS * QUEUE_DEPTH,
  parameter int TAW         = (TDEPTH > 1) ? $clog2(TDEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [TAW-1:0]                waddr,
  input  wire logic [llwd_pkg::TICKET_W-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [TAW-1:0]                raddr,
  output logic [llwd_pkg::TICKET_W-1:0]      rdata
);
  import llwd_pkg::*;

  logic [TICKET_W-1:0] mem [TDEPTH];
  logic [TICKET_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/least_loaded_window_dispatcher.sv -----
// ----------------------------------------------------------------------------
// least_loaded_window_dispatcher
// Least-loaded ticket dispatch with a FIFO per window, streaming ports.
// ----------------------------------------------------------------------------
// Enqueue: one window load read per cycle during the minimum search over the n
//   windows in use, then the decision; no new input until the result is written.
// Drain: per window in use a load read and a header, then its tickets from the
//   ticket memory; no new input until it ends; output stalls extend any of these.
// Reset (rst_n low, synchronous): state machine idle, output empty, register
//   back to 1, window valid bits cleared at once; no clearing pass.
`default_nettype none

module least_loaded_window_dispatcher #(
  parameter int MAX_WINDOWS = llwd_pkg::MAX_WINDOWS_DEF,
  parameter int QUEUE_DEPTH = llwd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [llwd_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [31:0]                in_tdata,   // service_time[15:0], ticket[25:16]
  input  wire logic [0:0]                 in_tuser,   // op[0]
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [39:0]                     out_tdata,  // window[1:0], load[25:2], ticket_out[35:26]
  output logic [1:0]                      out_tuser,  // kind[1:0]
  output logic                            out_tlast
);
  import llwd_pkg::*;

  localparam int WW     = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int NW     = $clog2(MAX_WINDOWS + 1);
  localparam int TDEPTH = MAX_WINDOWS * QUEUE_DEPTH;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]    cfg_r;
  logic [NW-1:0]       n_cfg;
  logic [WW-1:0]       nl_r, nl_nxt;
  logic [WW-1:0]       idx_r, idx_nxt;
  logic [WW-1:0]       best_r, best_nxt;
  logic [LOAD_W-1:0]   best_load_r, best_load_nxt;
  logic [CNT_W-1:0]    best_cnt_r, best_cnt_nxt;
  logic [STIME_W-1:0]  stime_r, stime_nxt;
  logic [TICKET_W-1:0] tick_r, tick_nxt;
  logic [LOAD_W-1:0]   load_r, load_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [WIN_W-1:0]    out_win_r, out_win_nxt;
  logic [LOAD_W-1:0]   out_load_r, out_load_nxt;
  logic [TICKET_W-1:0] out_tick_r, out_tick_nxt;
  logic                out_last_r, out_last_nxt;

  logic                out_free;
  logic                emit;
  logic                last_win;
  logic                last_tkt;
  logic [LOAD_W:0]     sum;
  logic [LOAD_W-1:0]   sat_load;

  logic                wm_clr, wm_we, wm_re;
  logic [WW-1:0]       wm_waddr, wm_raddr;
  win_entry_t          wm_wdata, wm_rdata;
  logic                tm_we, tm_re;
  logic [TAW-1:0]      tm_waddr, tm_raddr;
  logic [TICKET_W-1:0] tm_rdata;

  llwd_wmem #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .WW          (WW)
  ) u_wmem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (wm_clr),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (wm_wdata),
    .re    (wm_re),
    .raddr (wm_raddr),
    .rdata (wm_rdata)
  );

  llwd_tmem #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TDEPTH      (TDEPTH),
    .TAW         (TAW)
  ) u_tmem (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tick_r),
    .re    (tm_re),
    .raddr (tm_raddr),
    .rdata (tm_rdata)
  );

  // clamp the window count to 1..MAX_WINDOWS
  always_comb begin
    if (cfg_r == '0) begin
      n_cfg = NW'(1);
    end else if ({1'b0, cfg_r} > (CFG_W + 1)'(MAX_WINDOWS)) begin
      n_cfg = NW'(MAX_WINDOWS);
    end else begin
      n_cfg = NW'(cfg_r);
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign last_win = (idx_r == nl_r);
  assign last_tkt = (CNT_W'(j_r + 1'b1) == cnt_r);
  assign sum      = {1'b0, best_load_r} + (LOAD_W + 1)'(stime_r);
  assign sat_load = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == OP_DRAIN) ? ST_D_RDW : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_win) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_D_RDW: begin
        state_nxt = ST_D_HDR;
      end
      ST_D_HDR: begin
        if (out_free) begin
          if (cnt_r != '0) begin
            state_nxt = ST_D_TKT;
          end else begin
            state_nxt = last_win ? ST_IDLE : ST_D_RDW;
          end
        end
      end
      ST_D_TKT: begin
        if (out_free && last_tkt) begin
          state_nxt = last_win ? ST_IDLE : ST_D_RDW;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready     = 1'b0;
    wm_clr        = 1'b0;
    wm_we         = 1'b0;
    wm_waddr      = best_r;
    wm_wdata      = '{cnt: CNT_W'(best_cnt_r + 1'b1), load: sat_load};
    wm_re         = 1'b0;
    wm_raddr      = WW'(idx_r + 1'b1);
    tm_we         = 1'b0;
    tm_waddr      = TAW'(best_r) * TAW'(QUEUE_DEPTH) + TAW'(best_cnt_r);
    tm_re         = 1'b0;
    tm_raddr      = TAW'(idx_r) * TAW'(QUEUE_DEPTH) + TAW'(j_r);
    emit          = 1'b0;
    nl_nxt        = nl_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    best_load_nxt = best_load_r;
    best_cnt_nxt  = best_cnt_r;
    stime_nxt     = stime_r;
    tick_nxt      = tick_r;
    load_nxt      = load_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    out_kind_nxt  = out_kind_r;
    out_win_nxt   = out_win_r;
    out_load_nxt  = out_load_r;
    out_tick_nxt  = out_tick_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          wm_re     = 1'b1;
          wm_raddr  = '0;
          idx_nxt   = '0;
          nl_nxt    = WW'(n_cfg - 1'b1);
          stime_nxt = in_tdata[STIME_W-1:0];
          tick_nxt  = in_tdata[STIME_W +: TICKET_W];
        end
      end
      ST_SCAN: begin
        if (idx_r == '0 || wm_rdata.load < best_load_r) begin
          best_nxt      = idx_r;
          best_load_nxt = wm_rdata.load;
          best_cnt_nxt  = wm_rdata.cnt;
        end
        if (!last_win) begin
          wm_re   = 1'b1;
          idx_nxt = WW'(idx_r + 1'b1);
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          emit         = 1'b1;
          out_win_nxt  = WIN_W'(best_r);
          out_tick_nxt = tick_r;
          out_last_nxt = 1'b1;
          if (best_cnt_r >= CNT_W'(QUEUE_DEPTH)) begin
            out_kind_nxt = KIND_REJECTED;
            out_load_nxt = best_load_r;
          end else begin
            wm_we        = 1'b1;
            tm_we        = 1'b1;
            out_kind_nxt = KIND_ASSIGNED;
            out_load_nxt = sat_load;
          end
        end
      end
      ST_D_RDW: begin
        load_nxt = wm_rdata.load;
        cnt_nxt  = (wm_rdata.cnt > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : wm_rdata.cnt;
      end
      ST_D_HDR: begin
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_HEADER;
          out_win_nxt  = WIN_W'(idx_r);
          out_load_nxt = load_r;
          out_tick_nxt = '0;
          out_last_nxt = last_win && (cnt_r == '0);
          if (cnt_r != '0) begin
            tm_re    = 1'b1;
            tm_raddr = TAW'(idx_r) * TAW'(QUEUE_DEPTH);
            j_nxt    = '0;
          end else if (last_win) begin
            wm_clr = 1'b1;
          end else begin
            wm_re   = 1'b1;
            idx_nxt = WW'(idx_r + 1'b1);
          end
        end
      end
      ST_D_TKT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_DRAINED;
          out_win_nxt  = WIN_W'(idx_r);
          out_load_nxt = load_r;
          out_tick_nxt = tm_rdata;
          out_last_nxt = last_win && last_tkt;
          if (!last_tkt) begin
            tm_re    = 1'b1;
            tm_raddr = TAW'(idx_r) * TAW'(QUEUE_DEPTH) + TAW'(j_r + 1'b1);
            j_nxt    = CNT_W'(j_r + 1'b1);
          end else if (last_win) begin
            wm_clr = 1'b1;
          end else begin
            wm_re   = 1'b1;
            idx_nxt = WW'(idx_r + 1'b1);
          end
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    nl_r        <= nl_nxt;
    idx_r       <= idx_nxt;
    best_r      <= best_nxt;
    best_load_r <= best_load_nxt;
    best_cnt_r  <= best_cnt_nxt;
    stime_r     <= stime_nxt;
    tick_r      <= tick_nxt;
    load_r      <= load_nxt;
    cnt_r       <= cnt_nxt;
    j_r         <= j_nxt;
    out_kind_r  <= out_kind_nxt;
    out_win_r   <= out_win_nxt;
    out_load_r  <= out_load_nxt;
    out_tick_r  <= out_tick_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_tick_r, out_load_r, out_win_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit && out_last_nxt |=> state_r == ST_IDLE)
    else $error("final result not followed by idle");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result written over a pending one");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r <= nl_r)
    else $error("scan index beyond last window");

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_D_TKT |-> j_r < cnt_r)
    else $error("drained ticket beyond queue count");

  a_no_mem_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    wm_we |-> !wm_re && !wm_clr)
    else $error("window memory write overlaps read or clear");

endmodule

`default_nettype wire

// ----- bench/least_loaded_window_dispatcher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_window_dispatcher_tb
// Self-checking bench for the least-loaded ticket dispatcher. A directed table
// covers tie-breaking, full queues, drains after the window count shrinks and
// out-of-range counts. Random bursts of enqueues, most closed by a drain, follow, under
// several window counts and port idling patterns. Every result is checked
// field by field against the table or an in-bench model of loads and per-window queues.
// ----------------------------------------------------------------------------

module least_loaded_window_dispatcher_tb;
  import llwd_pkg::*;

  localparam int NUM_WIN      = MAX_WINDOWS_DEF;
  localparam int DEPTH        = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 180;
  // window counts visited by the random part, lowest slot first
  localparam logic [23:0] CFG_ORDER = {3'd6, 3'd5, 3'd3, 3'd2, 3'd7, 3'd0, 3'd4, 3'd1};

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [WIN_W-1:0]    win;
    logic [LOAD_W-1:0]   load;
    logic [TICKET_W-1:0] tkt;
    logic                last;
  } dispatch_result_t;

  typedef struct {
    bit                  do_cfg;
    logic [CFG_W-1:0]    cfg;
    logic                op;
    logic [STIME_W-1:0]  stime;
    logic [TICKET_W-1:0] tkt;
    bit                  typed;
    dispatch_result_t    want;
  } stim_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata   = '0;   // service_time[15:0], ticket[25:16]
  logic [0:0]          in_tuser   = '0;   // op[0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [39:0]         out_tdata;         // window[1:0], load[25:2], ticket_out[35:26]
  logic [1:0]          out_tuser;         // kind[1:0]
  logic                out_tlast;

  logic [CFG_W-1:0]    windows_reg;
  logic [LOAD_W-1:0]   win_load    [NUM_WIN];
  int                  win_count   [NUM_WIN];
  logic [TICKET_W-1:0] win_tickets [NUM_WIN][DEPTH];

  dispatch_result_t fresh_results[$];
  dispatch_result_t expected_results[$];
  stim_row_t        directed_rows[$];

  int mismatches     = 0;
  int results_seen   = 0;
  int items_sent     = 0;
  int drains_sent    = 0;
  int rejects_seen   = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;
  bit hold_flip      = 1'b0;
  bit hold_flip_seen = 1'b0;

  always #2 clk = ~clk;

  least_loaded_window_dispatcher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  function automatic int active_windows();
    if (int'(windows_reg) == 0) return 1;
    if (int'(windows_reg) > NUM_WIN) return NUM_WIN;
    return int'(windows_reg);
  endfunction

  function automatic logic [STIME_W-1:0] pick_stime();
    case ($urandom_range(9))
      0, 1, 2: return STIME_W'($urandom_range(0, 3));
      3:       return '1;
      default: return STIME_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void add_row(input bit do_cfg, input logic [CFG_W-1:0] cfg,
                                  input logic op, input logic [STIME_W-1:0] stime,
                                  input logic [TICKET_W-1:0] tkt, input bit typed,
                                  input logic [KIND_W-1:0] kind,
                                  input logic [WIN_W-1:0] win,
                                  input logic [LOAD_W-1:0] load);
    stim_row_t row;
    row.do_cfg = do_cfg;
    row.cfg    = cfg;
    row.op     = op;
    row.stime  = stime;
    row.tkt    = tkt;
    row.typed  = typed;
    row.want   = {kind, win, load, tkt, 1'b1};
    directed_rows.push_back(row);
  endfunction

  // Dispatch model: fills fresh_results with what one item produces.
  task automatic predict_dispatch(input logic op, input logic [STIME_W-1:0] stime,
                                  input logic [TICKET_W-1:0] tkt);
    int n;
    int best;
    logic [LOAD_W:0] sum;
    dispatch_result_t r;
    n = active_windows();
    fresh_results.delete();
    if (op == OP_ENQUEUE) begin
      best = 0;
      for (int i = 1; i < n; i++) begin
        if (win_load[i] < win_load[best]) best = i;
      end
      r.win  = WIN_W'(best);
      r.tkt  = tkt;
      r.last = 1'b1;
      if (win_count[best] >= DEPTH) begin
        r.kind = KIND_REJECTED;
        r.load = win_load[best];
        rejects_seen++;
      end else begin
        win_tickets[best][win_count[best]] = tkt;
        win_count[best]++;
        sum = {1'b0, win_load[best]} + (LOAD_W + 1)'(stime);
        win_load[best] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
        r.kind = KIND_ASSIGNED;
        r.load = win_load[best];
      end
      fresh_results.push_back(r);
    end else begin
      drains_sent++;
      for (int i = 0; i < n; i++) begin
        r.kind = KIND_HEADER;
        r.win  = WIN_W'(i);
        r.load = win_load[i];
        r.tkt  = '0;
        r.last = (i == n - 1) && (win_count[i] == 0);
        fresh_results.push_back(r);
        for (int j = 0; j < win_count[i]; j++) begin
          r.kind = KIND_DRAINED;
          r.tkt  = win_tickets[i][j];
          r.last = (i == n - 1) && (j == win_count[i] - 1);
          fresh_results.push_back(r);
        end
      end
      for (int i = 0; i < NUM_WIN; i++) begin
        win_load[i]  = '0;
        win_count[i] = 0;
      end
    end
  endtask

  // Offer one item, hold it until the transfer, then queue its results.
  task automatic send_item(input logic op, input logic [STIME_W-1:0] stime,
                           input logic [TICKET_W-1:0] tkt, input bit typed,
                           input dispatch_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, tkt, stime};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_dispatch(op, stime, tkt);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      foreach (fresh_results[k]) expected_results.push_back(fresh_results[k]);
    end
  endtask

  task automatic set_config(input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    windows_reg = value;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (hold_flip != hold_flip_seen) begin
      hold_flip_seen = hold_flip;
      hold_left      = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    dispatch_result_t got;
    dispatch_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[1:0], out_tdata[25:2], out_tdata[35:26], out_tlast};
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer kind %0d window %0d ticket %0h",
                                  got.kind, got.win, got.tkt));
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.win !== want.win)
          report_mismatch($sformatf("window %0d, expected %0d", got.win, want.win));
        if (got.load !== want.load)
          report_mismatch($sformatf("load %0h, expected %0h", got.load, want.load));
        if (got.tkt !== want.tkt)
          report_mismatch($sformatf("ticket %0h, expected %0h", got.tkt, want.tkt));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_results.size());
        $display("[least_loaded_window_dispatcher] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int  cfg_pick;
    int  start_count;
    int  burst;
    bit  held;
    bit  hold_now;
    cfg_pick = 0;
    held     = 1'b0;
    windows_reg = 3'd1;
    for (int i = 0; i < NUM_WIN; i++) begin
      win_load[i]  = '0;
      win_count[i] = 0;
    end
    send_idle_pct = 15;
    recv_idle_pct = 78;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // one window after reset, extreme fields
    add_row(0, 0, OP_ENQUEUE, 16'hFFFF, 10'h3FF, 1, KIND_ASSIGNED, 0, 24'h00FFFF);
    add_row(0, 0, OP_ENQUEUE, 16'h0000, 10'h000, 1, KIND_ASSIGNED, 0, 24'h00FFFF);
    add_row(0, 0, OP_DRAIN,   16'h1234, 10'h2AA, 0, '0, '0, '0);
    // four windows, ties go to the lowest index
    add_row(1, 4, OP_ENQUEUE, 16'd10,   10'd1,   1, KIND_ASSIGNED, 0, 24'd10);
    add_row(0, 0, OP_ENQUEUE, 16'd5,    10'd2,   1, KIND_ASSIGNED, 1, 24'd5);
    add_row(0, 0, OP_ENQUEUE, 16'd5,    10'd3,   1, KIND_ASSIGNED, 2, 24'd5);
    add_row(0, 0, OP_ENQUEUE, 16'd5,    10'd4,   1, KIND_ASSIGNED, 3, 24'd5);
    add_row(0, 0, OP_ENQUEUE, 16'd1,    10'd5,   1, KIND_ASSIGNED, 1, 24'd6);
    // shrink before drain: upper windows cleared unreported, then count above max
    add_row(1, 2, OP_DRAIN,   16'h0000, 10'h000, 0, '0, '0, '0);
    add_row(1, 7, OP_DRAIN,   16'hFFFF, 10'h3FF, 0, '0, '0, '0);
    // count of zero acts as one window; fill it, then overflow the queue
    add_row(1, 0, OP_ENQUEUE, 16'd3,    10'h155, 1, KIND_ASSIGNED, 0, 24'd3);
    for (int k = 0; k < DEPTH - 1; k++)
      add_row(0, 0, OP_ENQUEUE, 16'd0, TICKET_W'(10'h2A0 + k), 1, KIND_ASSIGNED, 0, 24'd3);
    add_row(0, 0, OP_ENQUEUE, 16'hFFFF, 10'h0F0, 1, KIND_REJECTED, 0, 24'd3);
    add_row(0, 0, OP_DRAIN,   16'h8001, 10'h201, 0, '0, '0, '0);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].do_cfg) set_config(directed_rows[r].cfg);
      send_item(directed_rows[r].op, directed_rows[r].stime, directed_rows[r].tkt,
                directed_rows[r].typed, directed_rows[r].want);
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 78 : 0;
      recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 15 : 0;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS / 3) begin
        set_config(CFG_ORDER[3 * (cfg_pick % 8) +: 3]);
        cfg_pick++;
        hold_now = (mode == 2) && !held;
        if (hold_now) begin
          hold_flip = ~hold_flip;
          held      = 1'b1;
        end
        burst = hold_now ? DEPTH * active_windows() + 3
                         : $urandom_range(1, DEPTH * active_windows() + 3);
        repeat (burst) begin
          if ($urandom_range(19) == 0)
            send_item(OP_DRAIN, pick_stime(), TICKET_W'($urandom_range(0, 1023)), 0, '0);
          else
            send_item(OP_ENQUEUE, pick_stime(), TICKET_W'($urandom_range(0, 1023)), 0, '0);
        end
        if ($urandom_range(9) < 8)
          send_item(OP_DRAIN, pick_stime(), TICKET_W'($urandom_range(0, 1023)), 0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d items (%0d drains, %0d rejected enqueues), checked %0d results,",
             items_sent, drains_sent, rejects_seen, results_seen);
    $display("window counts 0 to 7, idle and stalled ports, one long output hold.");
    if (mismatches == 0) begin
      $display("[least_loaded_window_dispatcher] OK");
    end else begin
      $display("[least_loaded_window_dispatcher] ERROR");
    end
    $finish;
  end

endmodule
